// ----- hw/rtl/ksm_pkg.sv -----
// ----------------------------------------------------------------------------
// ksm_pkg: shared types, codes and microprogram for the keyed slot mailbox
// Holds the result status codes, the control word layout, the step codes
// and the read-only microprogram that the sequencer steps through.
// ----------------------------------------------------------------------------
package ksm_pkg;

    // Result status codes
    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_FOUND  = 2'd2;
    localparam logic [1:0] ST_NONE   = 2'd3;

    // Width of the slot_index result field
    localparam int IDX_OUT_BITS = 4;

    // Step (microprogram address) codes
    localparam int STEP_BITS = 3;
    localparam logic [STEP_BITS-1:0] S_IDLE  = 3'd0;
    localparam logic [STEP_BITS-1:0] S_WSCAN = 3'd1;
    localparam logic [STEP_BITS-1:0] S_RSCAN = 3'd2;
    localparam logic [STEP_BITS-1:0] S_FULL  = 3'd3;
    localparam logic [STEP_BITS-1:0] S_NONE  = 3'd4;
    localparam logic [STEP_BITS-1:0] S_EMIT  = 3'd5;

    // Jump condition codes
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_OP_READ,
        COND_FREE,
        COND_HIT,
        COND_OUT_FREE
    } t_cond;

    // Datapath action, done when the condition holds
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_STORE,
        ACT_TAKE,
        ACT_FULL,
        ACT_MISS,
        ACT_EMIT
    } t_act;

    // One control word
    typedef struct packed {
        logic                 accept;  // step waits for an input item
        logic                 scan;    // on a miss, step the slot index
        t_cond                cond;
        t_act                 act;
        logic [STEP_BITS-1:0] jump;    // taken when cond holds
        logic [STEP_BITS-1:0] nxt;     // taken when cond fails
        logic [STEP_BITS-1:0] fail;    // taken when a scan runs off the end
    } t_uword;

    // Controls from sequencer to datapath
    typedef struct packed {
        logic in_ready;
        logic load;     // input item accepted this cycle
        logic fire;     // perform act
        t_act act;
        logic advance;  // step slot index
    } t_ctrl;

    // Status from datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic op_read;
        logic free;
        logic hit;
        logic last;
        logic out_free;
    } t_flags;

    // Microprogram
    function automatic t_uword ucode(input logic [STEP_BITS-1:0] step);
        t_uword w;
        w = '{accept: 1'b0, scan: 1'b0, cond: COND_ALWAYS, act: ACT_NONE,
              jump: S_IDLE, nxt: S_IDLE, fail: S_IDLE};
        unique case (step)
            S_IDLE: begin
                w.accept = 1'b1;
                w.cond   = COND_OP_READ;
                w.jump   = S_RSCAN;
                w.nxt    = S_WSCAN;
            end
            S_WSCAN: begin
                w.scan = 1'b1;
                w.cond = COND_FREE;
                w.act  = ACT_STORE;
                w.jump = S_EMIT;
                w.nxt  = S_WSCAN;
                w.fail = S_FULL;
            end
            S_RSCAN: begin
                w.scan = 1'b1;
                w.cond = COND_HIT;
                w.act  = ACT_TAKE;
                w.jump = S_EMIT;
                w.nxt  = S_RSCAN;
                w.fail = S_NONE;
            end
            S_FULL: begin
                w.act  = ACT_FULL;
                w.jump = S_EMIT;
            end
            S_NONE: begin
                w.act  = ACT_MISS;
                w.jump = S_EMIT;
            end
            S_EMIT: begin
                w.cond = COND_OUT_FREE;
                w.act  = ACT_EMIT;
                w.jump = S_IDLE;
                w.nxt  = S_EMIT;
            end
            default: begin
                w.jump = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/ksm_in_if.sv -----
// ----------------------------------------------------------------------------
// ksm_in_if: request channel of the keyed slot mailbox
// Carries one request item (operation, key, payload) with valid/ready.
// ----------------------------------------------------------------------------
interface ksm_in_if #(
    parameter int KEY_BITS     = 8,
    parameter int PAYLOAD_BITS = 32
);
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [KEY_BITS-1:0]     dest_key;
    logic [PAYLOAD_BITS-1:0] entry_payload;

    modport source (output valid, output operation, output dest_key,
                    output entry_payload, input ready);
    modport sink   (input valid, input operation, input dest_key,
                    input entry_payload, output ready);
endinterface

// ----- hw/rtl/ksm_out_if.sv -----
// ----------------------------------------------------------------------------
// ksm_out_if: result channel of the keyed slot mailbox
// Carries one result item (status, slot, key, payload) with valid/ready.
// ----------------------------------------------------------------------------
interface ksm_out_if #(
    parameter int KEY_BITS     = 8,
    parameter int PAYLOAD_BITS = 32
);
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic [ksm_pkg::IDX_OUT_BITS-1:0]  slot_index;
    logic [KEY_BITS-1:0]               out_key;
    logic [PAYLOAD_BITS-1:0]           out_payload;

    modport source (output valid, output status, output slot_index,
                    output out_key, output out_payload, input ready);
    modport sink   (input valid, input status, input slot_index,
                    input out_key, input out_payload, output ready);
endinterface

// ----- hw/rtl/ksm_ram.sv -----
// ----------------------------------------------------------------------------
// ksm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ksm_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/ksm_seq.sv -----
// ----------------------------------------------------------------------------
// ksm_seq: microcode sequencer
// Step counter over the read-only microprogram; evaluates the jump
// condition of each control word and issues datapath controls.
// ----------------------------------------------------------------------------
module ksm_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ksm_pkg::t_flags i_flags,
    output ksm_pkg::t_ctrl  o_ctrl
);

    logic [ksm_pkg::STEP_BITS-1:0] r_step;
    logic [ksm_pkg::STEP_BITS-1:0] n_step;
    ksm_pkg::t_uword               uw;
    logic                          cond_ok;
    logic                          hold;

    assign uw = ksm_pkg::ucode(r_step);

    // condition select
    always_comb begin
        unique case (uw.cond)
            ksm_pkg::COND_ALWAYS:   cond_ok = 1'b1;
            ksm_pkg::COND_OP_READ:  cond_ok = i_flags.op_read;
            ksm_pkg::COND_FREE:     cond_ok = i_flags.free;
            ksm_pkg::COND_HIT:      cond_ok = i_flags.hit;
            ksm_pkg::COND_OUT_FREE: cond_ok = i_flags.out_free;
            default:                cond_ok = 1'b0;
        endcase
    end

    // an accept step holds until an item arrives
    assign hold = uw.accept && !i_flags.in_valid;

    // next step
    always_comb begin
        if (hold) begin
            n_step = r_step;
        end else if (cond_ok) begin
            n_step = uw.jump;
        end else if (uw.scan && i_flags.last) begin
            n_step = uw.fail;
        end else begin
            n_step = uw.nxt;
        end
    end

    // datapath controls
    always_comb begin
        o_ctrl.in_ready = uw.accept;
        o_ctrl.load     = uw.accept && i_flags.in_valid;
        o_ctrl.fire     = cond_ok && !hold;
        o_ctrl.act      = uw.act;
        o_ctrl.advance  = uw.scan && !cond_ok && !i_flags.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ksm_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ----- hw/rtl/keyed_slot_mailbox_unit.sv -----
// ----------------------------------------------------------------------------
// keyed_slot_mailbox_unit: keyed slot mailbox
// Slot table with first-free insert and first-key-match take, run by a
// microcoded sequencer over a slot datapath.
// ----------------------------------------------------------------------------
// A write request stores its key and payload in the lowest-numbered free
// slot (status stored, slot index) or is refused when all SLOTS slots are
// used (status full). A read request takes the lowest-numbered used slot
// whose key matches, frees it and returns its slot, key and payload (status
// found), or reports status none. Every request yields exactly one result.
// Slots are scanned one per clock from slot 0 upward; the scan stops at the
// slot found or after the last slot. One request is in work at a time; the
// next is accepted while the previous result waits in the output register.
// Used flags clear at reset; no clearing pass is needed.
module keyed_slot_mailbox_unit #(
    parameter int SLOTS        = 16,
    parameter int KEY_BITS     = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ksm_in_if.sink  i_in,
    ksm_out_if.source o_out
);

    localparam int IDX_BITS = $clog2(SLOTS);
    localparam int ENT_BITS = KEY_BITS + PAYLOAD_BITS;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SLOTS - 1);

    ksm_pkg::t_ctrl  ctrl;
    ksm_pkg::t_flags flags;

    // request registers
    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [IDX_BITS-1:0]     r_idx;
    logic [IDX_BITS-1:0]     n_idx;
    logic [SLOTS-1:0]        r_used;

    // pending result
    logic [1:0]              r_res_status;
    logic [IDX_BITS-1:0]     r_res_idx;
    logic [KEY_BITS-1:0]     r_res_key;
    logic [PAYLOAD_BITS-1:0] r_res_pay;

    // output register
    logic                              r_out_valid;
    logic [1:0]                        r_out_status;
    logic [ksm_pkg::IDX_OUT_BITS-1:0]  r_out_idx;
    logic [KEY_BITS-1:0]               r_out_key;
    logic [PAYLOAD_BITS-1:0]           r_out_pay;

    // slot store
    logic                    ram_we;
    logic [ENT_BITS-1:0]     ram_rdata;
    logic [KEY_BITS-1:0]     rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    ksm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    // read address is the next slot index, so registered data matches r_idx during a scan
    always_comb begin
        if (ctrl.load) begin
            n_idx = '0;
        end else if (ctrl.advance) begin
            n_idx = r_idx + IDX_BITS'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    assign ram_we = ctrl.fire && (ctrl.act == ksm_pkg::ACT_STORE);

    ksm_ram #(
        .WIDTH (ENT_BITS),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata ({r_key, r_pay}),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[ENT_BITS-1:PAYLOAD_BITS];
    assign rd_pay = ram_rdata[PAYLOAD_BITS-1:0];

    // status toward the sequencer
    always_comb begin
        flags.in_valid = i_in.valid;
        flags.op_read  = i_in.operation;
        flags.free     = !r_used[r_idx];
        flags.hit      = r_used[r_idx] && (rd_key == r_key);
        flags.last     = (r_idx == LAST_IDX);
        flags.out_free = !r_out_valid || o_out.ready;
    end

    // request capture and slot index
    always_ff @(posedge i_clk) begin
        if (ctrl.load) begin
            r_key <= i_in.dest_key;
            r_pay <= i_in.entry_payload;
        end
        r_idx <= n_idx;
    end

    // used flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (ctrl.fire && ctrl.act == ksm_pkg::ACT_STORE) begin
            r_used[r_idx] <= 1'b1;
        end else if (ctrl.fire && ctrl.act == ksm_pkg::ACT_TAKE) begin
            r_used[r_idx] <= 1'b0;
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (ctrl.fire) begin
            case (ctrl.act)
                ksm_pkg::ACT_STORE: begin
                    r_res_status <= ksm_pkg::ST_STORED;
                    r_res_idx    <= r_idx;
                    r_res_key    <= '0;
                    r_res_pay    <= '0;
                end
                ksm_pkg::ACT_TAKE: begin
                    r_res_status <= ksm_pkg::ST_FOUND;
                    r_res_idx    <= r_idx;
                    r_res_key    <= rd_key;
                    r_res_pay    <= rd_pay;
                end
                ksm_pkg::ACT_FULL: begin
                    r_res_status <= ksm_pkg::ST_FULL;
                    r_res_idx    <= '0;
                    r_res_key    <= '0;
                    r_res_pay    <= '0;
                end
                ksm_pkg::ACT_MISS: begin
                    r_res_status <= ksm_pkg::ST_NONE;
                    r_res_idx    <= '0;
                    r_res_key    <= '0;
                    r_res_pay    <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.fire && ctrl.act == ksm_pkg::ACT_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.fire && ctrl.act == ksm_pkg::ACT_EMIT) begin
            r_out_status <= r_res_status;
            r_out_idx    <= ksm_pkg::IDX_OUT_BITS'(r_res_idx);
            r_out_key    <= r_res_key;
            r_out_pay    <= r_res_pay;
        end
    end

    assign i_in.ready        = ctrl.in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.slot_index  = r_out_idx;
    assign o_out.out_key     = r_out_key;
    assign o_out.out_payload = r_out_pay;

endmodule
